>>> rtl/intcode_processor_step_core_assert.svh
// Assertion macros for the intcode processor step core.
`ifndef INTCODE_PROCESSOR_STEP_CORE_ASSERT_SVH
`define INTCODE_PROCESSOR_STEP_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define IPS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("ips assertion failed");
`define IPS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("ips assertion failed");
`else
`define IPS_ASSERT(lbl, clk, rst, prop)
`define IPS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> rtl/ips_pkg.sv
`default_nettype none
package ips_pkg;

  localparam int unsigned MEM_WORDS = 65536;
  localparam int unsigned ADDR_W    = $clog2(MEM_WORDS);
  localparam int unsigned PC_W      = ADDR_W + 1;
  localparam int unsigned ADDR_IN_W = 16;
  localparam int unsigned WORD_W    = 64;
  localparam int unsigned REM_W     = 17;
  localparam int unsigned DEC_MOD   = 100000;
  localparam int unsigned DIV_TENK  = 10000;
  localparam int unsigned DIV_ONEK  = 1000;
  localparam int unsigned DIV_HUND  = 100;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_EXEC  = 2'd3;

  localparam logic [2:0] ST_OK   = 3'd0;
  localparam logic [2:0] ST_HALT = 3'd1;
  localparam logic [2:0] ST_NOIN = 3'd2;
  localparam logic [2:0] ST_BADI = 3'd3;
  localparam logic [2:0] ST_ADDR = 3'd4;

  localparam logic [6:0] OPC_ADD  = 7'd1;
  localparam logic [6:0] OPC_MUL  = 7'd2;
  localparam logic [6:0] OPC_IN   = 7'd3;
  localparam logic [6:0] OPC_OUT  = 7'd4;
  localparam logic [6:0] OPC_JT   = 7'd5;
  localparam logic [6:0] OPC_JF   = 7'd6;
  localparam logic [6:0] OPC_LT   = 7'd7;
  localparam logic [6:0] OPC_EQ   = 7'd8;
  localparam logic [6:0] OPC_RB   = 7'd9;
  localparam logic [6:0] OPC_HALT = 7'd99;

  localparam logic [3:0] MODE_IMM = 4'd1;
  localparam logic [3:0] MODE_REL = 4'd2;

  typedef enum logic [3:0] {
    I_ADD, I_MUL, I_IN, I_OUT, I_JT, I_JF, I_LT, I_EQ, I_RB, I_HALT, I_BAD
  } instr_e;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_LOAD, CMD_CLR_INIT, CMD_CLR_STEP, CMD_WRITE, CMD_READ, CMD_RDATA,
    CMD_BADADDR, CMD_HALTED, CMD_STOP, CMD_FETCH, CMD_DEC_LOAD, CMD_DEC_STEP,
    CMD_DIG_STEP, CMD_PREAD, CMD_PADDR, CMD_OREAD, CMD_OVAL, CMD_KINC, CMD_MUL_STEP,
    CMD_EXEC, CMD_PUSH
  } cmd_e;

  typedef enum logic [4:0] {
    S_CLR_RST, S_IDLE, S_DISPATCH, S_CLR_OP, S_READ_WAIT, S_FETCH_WAIT, S_DEC, S_DIG,
    S_CHECK, S_PARAM, S_PWAIT, S_OREAD, S_OWAIT, S_NEXT, S_EXEC, S_FINISH
  } state_e;

  typedef struct packed {
    cmd_e       op;
    logic [2:0] code;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       halted;
    logic       addr_ok;
    logic       pc_ok;
    logic       clr_last;
    logic       dec_last;
    logic       dig_last;
    instr_e     instr;
    logic       dec_bad;
    logic       parm_ok;
    logic       p_imm;
    logic       p_a_ok;
    logic       p_read;
    logic       k_last;
    logic       mul_done;
    logic [2:0] exec_code;
    logic       out_full;
  } stat_t;

  function automatic logic [REM_W-1:0] mod_step(input logic [REM_W+3:0] v);
    logic [REM_W+3:0] r;
    r = v;
    for (int q = 1; q < 16; q++) begin
      if (v >= (REM_W+4)'(q * DEC_MOD)) r = v - (REM_W+4)'(q * DEC_MOD);
    end
    return REM_W'(r);
  endfunction

  function automatic logic [REM_W-1:0] dig_div(input logic [1:0] step);
    logic [REM_W-1:0] d;
    case (step)
      2'd0:    d = REM_W'(DIV_TENK);
      2'd1:    d = REM_W'(DIV_ONEK);
      default: d = REM_W'(DIV_HUND);
    endcase
    return d;
  endfunction

  function automatic logic [3:0] dec_digit(input logic [REM_W-1:0] v, input logic [1:0] step);
    logic [3:0] d;
    logic [REM_W-1:0] dv;
    d = 4'd0;
    dv = dig_div(step);
    for (int q = 1; q < 10; q++) begin
      if (v >= REM_W'(q * dv)) d = 4'(q);
    end
    return d;
  endfunction

  function automatic logic [REM_W-1:0] dec_rest(input logic [REM_W-1:0] v,
                                                 input logic [1:0] step);
    logic [REM_W-1:0] r;
    logic [REM_W-1:0] dv;
    r = v;
    dv = dig_div(step);
    for (int q = 1; q < 10; q++) begin
      if (v >= REM_W'(q * dv)) r = v - REM_W'(q * dv);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/ips_item_if.sv
`default_nettype none
interface ips_item_if;
  import ips_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               op;
  logic [ADDR_IN_W-1:0]     address;
  logic signed [WORD_W-1:0] data;
  logic                     in_valid;
  logic signed [WORD_W-1:0] in_value;
  modport source (output valid, op, address, data, in_valid, in_value, input ready);
  modport sink (input valid, op, address, data, in_valid, in_value, output ready);
endinterface
`default_nettype wire

>>> rtl/ips_result_if.sv
`default_nettype none
interface ips_result_if;
  import ips_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [2:0]               status;
  logic                     input_taken;
  logic                     out_valid;
  logic signed [WORD_W-1:0] out_value;
  logic signed [WORD_W-1:0] read_data;
  modport source (output valid, status, input_taken, out_valid, out_value, read_data,
                  input ready);
  modport sink (input valid, status, input_taken, out_valid, out_value, read_data,
                output ready);
endinterface
`default_nettype wire

>>> rtl/ips_ram.sv
`default_nettype none
module ips_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

>>> rtl/ips_ctrl.sv
`default_nettype none
module ips_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  ips_pkg::stat_t stat,
  output ips_pkg::cmd_t  cmd
);
  import ips_pkg::*;

  state_e state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLR_RST;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd.op     = CMD_NONE;
    cmd.code   = ST_OK;
    item_ready = 1'b0;
    case (state)
      S_CLR_RST: begin
        cmd.op = CMD_CLR_STEP;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.op     = CMD_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.op)
          OP_CLEAR: begin
            cmd.op     = CMD_CLR_INIT;
            state_next = S_CLR_OP;
          end
          OP_WRITE: begin
            cmd.op     = stat.addr_ok ? CMD_WRITE : CMD_BADADDR;
            state_next = S_FINISH;
          end
          OP_READ: begin
            if (stat.addr_ok) begin
              cmd.op     = CMD_READ;
              state_next = S_READ_WAIT;
            end else begin
              cmd.op     = CMD_BADADDR;
              state_next = S_FINISH;
            end
          end
          default: begin
            if (stat.halted) begin
              cmd.op     = CMD_HALTED;
              state_next = S_FINISH;
            end else if (!stat.pc_ok) begin
              cmd.op     = CMD_STOP;
              cmd.code   = ST_ADDR;
              state_next = S_FINISH;
            end else begin
              cmd.op     = CMD_FETCH;
              state_next = S_FETCH_WAIT;
            end
          end
        endcase
      end
      S_CLR_OP: begin
        cmd.op = CMD_CLR_STEP;
        if (stat.clr_last) state_next = S_FINISH;
      end
      S_READ_WAIT: begin
        cmd.op     = CMD_RDATA;
        state_next = S_FINISH;
      end
      S_FETCH_WAIT: begin
        cmd.op     = CMD_DEC_LOAD;
        state_next = S_DEC;
      end
      S_DEC: begin
        cmd.op = CMD_DEC_STEP;
        if (stat.dec_last) state_next = S_DIG;
      end
      S_DIG: begin
        cmd.op = CMD_DIG_STEP;
        if (stat.dig_last) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (stat.instr == I_HALT) begin
          cmd.op     = CMD_STOP;
          cmd.code   = ST_HALT;
          state_next = S_FINISH;
        end else if (stat.instr == I_BAD || stat.dec_bad) begin
          cmd.op     = CMD_STOP;
          cmd.code   = ST_BADI;
          state_next = S_FINISH;
        end else begin
          state_next = S_PARAM;
        end
      end
      S_PARAM: begin
        if (!stat.parm_ok) begin
          cmd.op     = CMD_STOP;
          cmd.code   = ST_ADDR;
          state_next = S_FINISH;
        end else begin
          cmd.op     = CMD_PREAD;
          state_next = S_PWAIT;
        end
      end
      S_PWAIT: begin
        if (!stat.p_imm && !stat.p_a_ok) begin
          cmd.op     = CMD_STOP;
          cmd.code   = ST_ADDR;
          state_next = S_FINISH;
        end else begin
          cmd.op     = CMD_PADDR;
          state_next = stat.p_read ? S_OREAD : S_NEXT;
        end
      end
      S_OREAD: begin
        cmd.op     = CMD_OREAD;
        state_next = S_OWAIT;
      end
      S_OWAIT: begin
        cmd.op     = CMD_OVAL;
        state_next = S_NEXT;
      end
      S_NEXT: begin
        if (stat.k_last) begin
          state_next = S_EXEC;
        end else begin
          cmd.op     = CMD_KINC;
          state_next = S_PARAM;
        end
      end
      S_EXEC: begin
        if (stat.instr == I_MUL && !stat.mul_done) begin
          cmd.op = CMD_MUL_STEP;
        end else if (stat.exec_code != ST_OK) begin
          cmd.op     = CMD_STOP;
          cmd.code   = stat.exec_code;
          state_next = S_FINISH;
        end else begin
          cmd.op     = CMD_EXEC;
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!stat.out_full) begin
          cmd.op     = CMD_PUSH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/ips_datapath.sv
`default_nettype none
`include "intcode_processor_step_core_assert.svh"
module ips_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  ips_pkg::cmd_t                    cmd,
  output ips_pkg::stat_t                   stat,
  input  logic [1:0]                       in_op,
  input  logic [ips_pkg::ADDR_IN_W-1:0]    in_address,
  input  logic signed [ips_pkg::WORD_W-1:0] in_data,
  input  logic                             in_inv,
  input  logic signed [ips_pkg::WORD_W-1:0] in_inval,
  ips_result_if.source                     result
);
  import ips_pkg::*;

  logic [1:0]           it_op;
  logic [ADDR_IN_W-1:0] it_addr;
  logic [WORD_W-1:0]    it_data;
  logic                 it_inv;
  logic [WORD_W-1:0]    it_inval;

  logic [PC_W-1:0]   pc;
  logic [31:0]       rb;
  logic [2:0]        halt;
  logic [ADDR_W-1:0] ctr;

  logic [WORD_W-1:0] mag;
  logic [REM_W-1:0]  rem;
  logic [3:0]        nib;
  logic [1:0]        dig;
  logic [3:0]        mode [3];
  logic [1:0]        k;
  logic [WORD_W-1:0] val [3];
  logic [ADDR_W-1:0] addr [3];
  logic [1:0]        mcnt;
  logic [WORD_W-1:0] prod;
  logic [31:0]       mid_sum;

  logic [2:0]        res_status;
  logic              res_taken;
  logic              res_outv;
  logic [WORD_W-1:0] res_outval;
  logic [WORD_W-1:0] res_rdata;
  logic              out_full;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  instr_e            instr;
  logic [1:0]        np;
  logic              dest_v;
  logic [1:0]        dest_i;
  logic              dec_bad;
  logic [PC_W-1:0]   p_addr;
  logic [PC_W-1:0]   pc_adv;
  logic [3:0]        m;
  logic [WORD_W-1:0] rb_ext;
  logic [WORD_W-1:0] p_a;
  logic              take;
  logic [2:0]        exec_code;
  logic [31:0]       ma;
  logic [31:0]       mb;
  logic [WORD_W-1:0] pp;
  logic [WORD_W-1:0] alu;
  logic [REM_W+3:0]  dec_v;

  ips_ram #(.WIDTH(WORD_W), .DEPTH(MEM_WORDS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    case (rem[6:0])
      OPC_ADD:  instr = I_ADD;
      OPC_MUL:  instr = I_MUL;
      OPC_IN:   instr = I_IN;
      OPC_OUT:  instr = I_OUT;
      OPC_JT:   instr = I_JT;
      OPC_JF:   instr = I_JF;
      OPC_LT:   instr = I_LT;
      OPC_EQ:   instr = I_EQ;
      OPC_RB:   instr = I_RB;
      OPC_HALT: instr = I_HALT;
      default:  instr = I_BAD;
    endcase
    dest_v = 1'b0;
    dest_i = 2'd0;
    case (instr)
      I_ADD, I_MUL, I_LT, I_EQ: begin
        np     = 2'd3;
        dest_v = 1'b1;
        dest_i = 2'd2;
      end
      I_IN: begin
        np     = 2'd1;
        dest_v = 1'b1;
      end
      I_JT, I_JF: np = 2'd2;
      default:    np = 2'd1;
    endcase
    dec_bad = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < np) begin
        if (mode[i] > MODE_REL || (dest_v && dest_i == 2'(i) && mode[i] == MODE_IMM))
          dec_bad = 1'b1;
      end
    end
  end

  always_comb begin
    p_addr = PC_W'(pc + PC_W'(k) + PC_W'(1));
    pc_adv = PC_W'(pc + PC_W'(np) + PC_W'(1));
    m      = mode[k];
    rb_ext = {{32{rb[31]}}, rb};
    p_a    = (m == MODE_REL) ? rb_ext + ram_rdata : ram_rdata;
    take   = ((val[0] != '0) == (instr == I_JT));
    exec_code = ST_OK;
    if (instr == I_IN && !it_inv) exec_code = ST_NOIN;
    if ((instr == I_JT || instr == I_JF) && take && !(val[1] < WORD_W'(MEM_WORDS)))
      exec_code = ST_ADDR;
    ma = (mcnt == 2'd2) ? val[0][63:32] : val[0][31:0];
    mb = (mcnt == 2'd1) ? val[1][63:32] : val[1][31:0];
    pp = ma * mb;
    dec_v = {rem, mag[63:60]};
    case (instr)
      I_MUL:   alu = prod + {mid_sum, 32'd0};
      I_LT:    alu = WORD_W'($signed(val[0]) < $signed(val[1]));
      I_EQ:    alu = WORD_W'(val[0] == val[1]);
      I_IN:    alu = it_inval;
      default: alu = val[0] + val[1];
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = '0;
    ram_wdata = alu;
    case (cmd.op)
      CMD_CLR_STEP: begin
        ram_we    = 1'b1;
        ram_addr  = ctr;
        ram_wdata = '0;
      end
      CMD_WRITE: begin
        ram_we    = 1'b1;
        ram_addr  = ADDR_W'(it_addr);
        ram_wdata = it_data;
      end
      CMD_READ:  ram_addr = ADDR_W'(it_addr);
      CMD_FETCH: ram_addr = ADDR_W'(pc);
      CMD_PREAD: ram_addr = ADDR_W'(p_addr);
      CMD_OREAD: ram_addr = addr[k];
      CMD_EXEC: begin
        ram_we   = (instr == I_ADD || instr == I_MUL || instr == I_LT || instr == I_EQ ||
                    instr == I_IN);
        ram_addr = (instr == I_IN) ? addr[0] : addr[2];
      end
      default: ram_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= '0;
      rb       <= '0;
      halt     <= ST_OK;
      ctr      <= '0;
      out_full <= 1'b0;
      k        <= '0;
      nib      <= '0;
      dig      <= '0;
      mcnt     <= '0;
    end else begin
      if (result.valid && result.ready) out_full <= 1'b0;
      case (cmd.op)
        CMD_LOAD: begin
          it_op      <= in_op;
          it_addr    <= in_address;
          it_data    <= in_data;
          it_inv     <= in_inv;
          it_inval   <= in_inval;
          k          <= '0;
          dig        <= '0;
          mcnt       <= '0;
          res_status <= ST_OK;
          res_taken  <= 1'b0;
          res_outv   <= 1'b0;
          res_outval <= '0;
          res_rdata  <= '0;
        end
        CMD_CLR_INIT: begin
          pc   <= '0;
          rb   <= '0;
          halt <= ST_OK;
          ctr  <= '0;
        end
        CMD_CLR_STEP: ctr <= ADDR_W'(ctr + 1'b1);
        CMD_RDATA:    res_rdata <= ram_rdata;
        CMD_BADADDR:  res_status <= ST_ADDR;
        CMD_HALTED:   res_status <= halt;
        CMD_STOP: begin
          halt       <= cmd.code;
          res_status <= cmd.code;
        end
        CMD_DEC_LOAD: begin
          mag <= ram_rdata[63] ? WORD_W'(-ram_rdata) : ram_rdata;
          rem <= '0;
          nib <= '0;
        end
        CMD_DEC_STEP: begin
          rem <= mod_step(dec_v);
          mag <= {mag[59:0], 4'd0};
          nib <= 4'(nib + 1'b1);
        end
        CMD_DIG_STEP: begin
          mode[2'(2'd2 - dig)] <= dec_digit(rem, dig);
          rem                  <= dec_rest(rem, dig);
          dig                  <= 2'(dig + 1'b1);
        end
        CMD_PADDR: begin
          if (m == MODE_IMM) val[k] <= ram_rdata;
          else               addr[k] <= ADDR_W'(p_a);
        end
        CMD_OVAL: val[k] <= ram_rdata;
        CMD_KINC: k <= 2'(k + 1'b1);
        CMD_MUL_STEP: begin
          case (mcnt)
            2'd0:    prod    <= pp;
            2'd1:    mid_sum <= pp[31:0];
            default: mid_sum <= mid_sum + pp[31:0];
          endcase
          mcnt <= 2'(mcnt + 1'b1);
        end
        CMD_EXEC: begin
          pc <= pc_adv;
          case (instr)
            I_IN:  res_taken <= 1'b1;
            I_OUT: begin
              res_outv   <= 1'b1;
              res_outval <= val[0];
            end
            I_JT, I_JF: if (take) pc <= PC_W'(val[1][ADDR_W-1:0]);
            I_RB:    rb <= rb + val[0][31:0];
            default: res_taken <= 1'b0;
          endcase
        end
        CMD_PUSH: begin
          out_full           <= 1'b1;
          result.status      <= res_status;
          result.input_taken <= res_taken;
          result.out_valid   <= res_outv;
          result.out_value   <= res_outval;
          result.read_data   <= res_rdata;
        end
        default: k <= k;
      endcase
    end
  end

  assign result.valid = out_full;

  always_comb begin
    stat.op        = it_op;
    stat.halted    = (halt != ST_OK);
    stat.addr_ok   = (WORD_W'(it_addr) < WORD_W'(MEM_WORDS));
    stat.pc_ok     = (WORD_W'(pc) < WORD_W'(MEM_WORDS));
    stat.clr_last  = (WORD_W'(ctr) == WORD_W'(MEM_WORDS - 1));
    stat.dec_last  = (nib == 4'd15);
    stat.dig_last  = (dig == 2'd2);
    stat.instr     = instr;
    stat.dec_bad   = dec_bad;
    stat.parm_ok   = (WORD_W'(p_addr) < WORD_W'(MEM_WORDS));
    stat.p_imm     = (m == MODE_IMM);
    stat.p_a_ok    = (p_a < WORD_W'(MEM_WORDS));
    stat.p_read    = (m != MODE_IMM) && !(dest_v && dest_i == k);
    stat.k_last    = (k == 2'(np - 2'd1));
    stat.mul_done  = (mcnt == 2'd3);
    stat.exec_code = exec_code;
    stat.out_full  = out_full;
  end

  `IPS_ASSERT(a_stop_halts, clk, rst, cmd.op == CMD_STOP |=> halt != ST_OK)
  `IPS_ASSERT(a_stop_keeps_pc, clk, rst, cmd.op == CMD_STOP |=> $stable(pc))
  `IPS_ASSERT(a_push_empty, clk, rst, cmd.op == CMD_PUSH |-> !out_full)
  `IPS_ASSERT(a_halted_pc, clk, rst, halt != ST_OK && cmd.op != CMD_CLR_INIT |=> $stable(pc))
endmodule
`default_nettype wire

>>> rtl/intcode_processor_step_core.sv
`default_nettype none
// Decimal-coded processor with a 65536-word single-port memory. After reset, and for a
// clear item, a sweep zeroes the memory at one word a cycle (a clear item adds its accept,
// dispatch and result cycles) and no item is taken meanwhile. A write item runs accept,
// dispatch and result; a read adds a data cycle. An execute item that runs takes accept,
// dispatch and fetch, 16 nibble steps and 3 digit steps of the decimal decode, a check
// cycle, a parameter read, address and next step for each operand, with an operand read
// and wait when it comes from memory, the partial-product steps of a multiply, then the
// execute and the result cycle. A halted machine answers after dispatch, a halt or an
// invalid instruction word after the check. The single memory port and nibble-serial
// decode set this sequence. The result sits in an output register, so the next item is
// taken while it waits; the result cycle of that item holds until the register is empty.
module intcode_processor_step_core (
  input  logic         clk,
  input  logic         rst,
  ips_item_if.sink     item,
  ips_result_if.source result
);
  import ips_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ips_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  ips_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_op      (item.op),
    .in_address (item.address),
    .in_data    (item.data),
    .in_inv     (item.in_valid),
    .in_inval   (item.in_value),
    .result     (result)
  );
endmodule
`default_nettype wire
